>>> sv/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg
// shared types, constants and the lookup2 mix row for the byte hash core
// ----------------------------------------------------------------------------
package lbh_pkg;

  localparam logic [31:0] GOLDEN_INIT = 32'h9e3779b9;
  localparam logic [31:0] C_INIT      = 32'd13;

  // bytes held in the front before a block is complete
  localparam int TAIL_BYTES = 11;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // the mix has nine rows, one per cycle in the back
  localparam logic [3:0] ROW_LAST = 4'd8;

  // one unit of work for the back
  typedef struct packed {
    logic [31:0] add_a;  // block word or tail word for a
    logic [31:0] add_b;  // block word or tail word for b
    logic [31:0] add_c;  // block word or tail word for c
    logic [31:0] len;    // key length, used when fin is set
    logic        blk;    // add words are a full block, mix it
    logic        fin;    // finish the key and emit the hash
  } lbh_job_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lbh_words_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX,
    BK_TAIL,
    BK_EMIT
  } lbh_back_state_t;

  // one row of the lookup2 mix: x = (x - y - z) ^ (z shifted)
  function automatic lbh_words_t mix_row(input logic [3:0] row, input lbh_words_t w);
    lbh_words_t r;
    r = w;
    unique case (row)
      4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

>>> sv/lbh_front.sv
// ----------------------------------------------------------------------------
// lbh_front
// takes key bytes, packs blocks and tails, and issues jobs to the queue
// ----------------------------------------------------------------------------
module lbh_front import lbh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       last,
  output logic       job_valid,
  input  logic       job_ready,
  output lbh_job_t   job
);

  logic [7:0]  block_store [TAIL_BYTES];
  logic [3:0]  block_position;
  logic [31:0] key_length;

  logic        take;
  logic        full_block;
  logic [3:0]  pos_after;
  logic [31:0] len_next;
  logic [7:0]  tail [TAIL_BYTES];
  logic [7:0]  tb;

  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    full_block = has_byte && (block_position == 4'(TAIL_BYTES));
    len_next   = key_length + 32'(has_byte);
    pos_after  = (has_byte && !full_block) ? block_position + 4'd1 : block_position;
    for (int i = 0; i < TAIL_BYTES; i++) begin
      tb      = (has_byte && block_position == 4'(i)) ? data_byte : block_store[i];
      tail[i] = (4'(i) < pos_after) ? tb : 8'h00;
    end

    job_valid = in_valid && (full_block || last);
    job.len   = len_next;
    job.blk   = full_block;
    job.fin   = last;
    if (full_block) begin
      job.add_a = {block_store[3], block_store[2], block_store[1], block_store[0]};
      job.add_b = {block_store[7], block_store[6], block_store[5], block_store[4]};
      job.add_c = {data_byte, block_store[10], block_store[9], block_store[8]};
    end else begin
      job.add_a = {tail[3], tail[2], tail[1], tail[0]};
      job.add_b = {tail[7], tail[6], tail[5], tail[4]};
      job.add_c = {tail[10], tail[9], tail[8], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position <= '0;
      key_length     <= '0;
    end else if (take) begin
      if (last) begin
        block_position <= '0;
        key_length     <= '0;
      end else begin
        block_position <= full_block ? 4'd0 : pos_after;
        key_length     <= len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_byte && !full_block) begin
      block_store[block_position] <= data_byte;
    end
  end

endmodule

>>> sv/lbh_queue.sv
// ----------------------------------------------------------------------------
// lbh_queue
// small job fifo between front and back
// ----------------------------------------------------------------------------
module lbh_queue import lbh_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  lbh_job_t push_job,
  output logic     pop_valid,
  input  logic     pop,
  output lbh_job_t pop_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lbh_job_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> sv/lbh_back.sv
// ----------------------------------------------------------------------------
// lbh_back
// holds a, b, c, runs the mix one row per cycle and emits the hash
// ----------------------------------------------------------------------------
module lbh_back import lbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  lbh_job_t    q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  localparam lbh_words_t WORDS_INIT = '{a: GOLDEN_INIT, b: GOLDEN_INIT, c: C_INIT};

  lbh_back_state_t state;
  lbh_back_state_t state_next;
  lbh_words_t      w;
  logic [3:0]      row;
  logic            cur_blk;
  logic            cur_fin;
  logic [31:0]     cur_len;
  logic            emit_go;
  logic [31:0]     len_in;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit_go    = 1'b0;
    len_in     = (q_job.fin && !q_job.blk) ? q_job.len : 32'd0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) state_next = BK_MIX;
      end
      BK_MIX: begin
        if (row == ROW_LAST) begin
          priority if (cur_fin && cur_blk) state_next = BK_TAIL;
          else if (cur_fin)                state_next = BK_EMIT;
          else                             state_next = BK_IDLE;
        end
      end
      BK_TAIL: state_next = BK_MIX;
      BK_EMIT: begin
        emit_go = !out_valid || out_ready;
        if (emit_go) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w         <= WORDS_INIT;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_go) out_valid <= 1'b0;
      unique case (state)
        BK_IDLE: begin
          if (q_valid) begin
            w.a <= w.a + q_job.add_a;
            w.b <= w.b + q_job.add_b;
            w.c <= w.c + q_job.add_c + len_in;
          end
        end
        BK_MIX:  w   <= mix_row(row, w);
        BK_TAIL: w.c <= w.c + cur_len;
        BK_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            w         <= WORDS_INIT;
          end
        end
        default: w <= w;
      endcase
    end
  end

  // job bookkeeping and result payload, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          cur_blk <= q_job.blk;
          cur_fin <= q_job.fin;
          cur_len <= q_job.len;
          row     <= '0;
        end
      end
      BK_MIX: row <= row + 4'd1;
      BK_TAIL: begin
        cur_blk <= 1'b0;
        row     <= '0;
      end
      BK_EMIT: begin
        if (emit_go) hash_value <= w.c;
      end
      default: row <= '0;
    endcase
  end

endmodule

>>> sv/lookup2_byte_hash_core.sv
// ----------------------------------------------------------------------------
// lookup2_byte_hash_core
// streaming 32-bit lookup2 hash of a key delivered one byte per transfer
// ----------------------------------------------------------------------------
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, data_byte, has_byte,  | into core
//           | last                                      |
//   out     | out_valid, out_ready, hash_value          | out of core
//
// the front takes one transfer per cycle whenever the job queue has room
// each full 12-byte block costs the back one add and nine mix rows
// each key end adds a length and tail add, nine mix rows and one emit
// the back's single mix row unit sets the sustained rate; the queue absorbs
// bursts, and in_ready drops only while the queue is full
// a stalled out channel holds the result register; the back waits there
// while the front keeps filling the queue
// rst is synchronous and returns a, b, c to their initial values, empties
// the queue and drops out_valid
// ----------------------------------------------------------------------------
module lookup2_byte_hash_core import lbh_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  // front to queue
  logic     job_valid;
  logic     job_ready;
  lbh_job_t job;

  // queue to back
  logic     q_valid;
  logic     q_pop;
  lbh_job_t q_job;

  // byte packing, block detection and tail assembly
  lbh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // decouples byte intake from the multi-cycle mix
  lbh_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_job)
  );

  // word state, mix sequencer and result register
  lbh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

>>> sv/lbh_checker.sv
// ----------------------------------------------------------------------------
// lbh_checker
// port-level checks on the byte hash core, bound to the top level
// ----------------------------------------------------------------------------
module lbh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        has_byte,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] hash_value
);

  // reset leaves no result pending
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // reset empties the queue so input is taken at once
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  // a waiting input transfer stays offered with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable({data_byte, has_byte, last}))
    else $error("input changed before transfer");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hash_value))
    else $error("hash_value changed while stalled");

endmodule

bind lookup2_byte_hash_core lbh_checker u_lbh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .data_byte  (data_byte),
  .has_byte   (has_byte),
  .last       (last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hash_value (hash_value)
);

>>> bench/lookup2_byte_hash_checker.sv
// ----------------------------------------------------------------------------
// lookup2_byte_hash_checker
// watches both channels of the byte hash core, predicts each key's lookup2
// hash from the accepted bytes and compares it with the emitted hash
// ----------------------------------------------------------------------------
module lookup2_byte_hash_checker import lbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] hash_value,
  output int          fail_count,
  output int          outstanding
);

  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [31:0] hash_c;
  logic [7:0]  tail_bytes [0:TAIL_BYTES-1];
  int          tail_count;
  logic [31:0] key_len;
  logic [31:0] expected_hashes [$];
  int          mismatches;

  initial begin
    mismatches = 0;
  end

  task automatic rearm_words();
    hash_a     = GOLDEN_INIT;
    hash_b     = GOLDEN_INIT;
    hash_c     = C_INIT;
    tail_count = 0;
    key_len    = '0;
  endtask

  // full nine-step lookup2 mix over the three words
  task automatic lookup2_mix();
    hash_a = (hash_a - hash_b - hash_c) ^ (hash_c >> 13);
    hash_b = (hash_b - hash_c - hash_a) ^ (hash_a << 8);
    hash_c = (hash_c - hash_a - hash_b) ^ (hash_b >> 13);
    hash_a = (hash_a - hash_b - hash_c) ^ (hash_c >> 12);
    hash_b = (hash_b - hash_c - hash_a) ^ (hash_a << 16);
    hash_c = (hash_c - hash_a - hash_b) ^ (hash_b >> 5);
    hash_a = (hash_a - hash_b - hash_c) ^ (hash_c >> 3);
    hash_b = (hash_b - hash_c - hash_a) ^ (hash_a << 10);
    hash_c = (hash_c - hash_a - hash_b) ^ (hash_b >> 15);
  endtask

  task automatic absorb_transfer(input logic [7:0] b, input logic hb, input logic lst);
    int          i;
    logic [31:0] v;
    if (hb) begin
      key_len = key_len + 32'd1;
      if (tail_count == TAIL_BYTES) begin
        // twelfth byte completes the block
        hash_a = hash_a + {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]};
        hash_b = hash_b + {tail_bytes[7], tail_bytes[6], tail_bytes[5], tail_bytes[4]};
        hash_c = hash_c + {b, tail_bytes[10], tail_bytes[9], tail_bytes[8]};
        lookup2_mix();
        tail_count = 0;
      end else begin
        tail_bytes[tail_count] = b;
        tail_count = tail_count + 1;
      end
    end
    if (lst) begin
      hash_c = hash_c + key_len;
      for (i = 0; i < tail_count; i++) begin
        v = {24'd0, tail_bytes[i]};
        if (i < 4)
          hash_a = hash_a + (v << (8 * i));
        else if (i < 8)
          hash_b = hash_b + (v << (8 * (i - 4)));
        else
          // low byte of c belongs to the length
          hash_c = hash_c + (v << (8 * (i - 7)));
      end
      lookup2_mix();
      expected_hashes.push_back(hash_c);
      rearm_words();
    end
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      rearm_words();
      expected_hashes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected hash %08h with none pending", hash_value);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("hash mismatch: expected %08h actual %08h", want, hash_value);
          end
        end
      end
      if (in_valid && in_ready)
        absorb_transfer(data_byte, has_byte, last);
    end
    fail_count  <= mismatches;
    outstanding <= expected_hashes.size();
  end

endmodule

>>> bench/tb_lookup2_byte_hash_core.sv
// ----------------------------------------------------------------------------
// tb_lookup2_byte_hash_core
// streams directed and random keys into the byte hash core with random
// gaps on both channels; a side checker predicts and compares every hash
// ----------------------------------------------------------------------------
module tb_lookup2_byte_hash_core;

  // slowest legal run is well under this limit
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 1900;
  // drain allowance after the last hash, covers a block plus a key end
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] hash_value;

  int fail_count;
  int outstanding;
  int cycle_count;
  // while set, neither side inserts gaps
  logic steady;

  lookup2_byte_hash_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  lookup2_byte_hash_checker hash_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .has_byte    (has_byte),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the core hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lookup2_byte_hash_core failed");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    else if (r < 95)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 60);
  endfunction

  // one transfer on the in channel; entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // valid stays high across back-to-back transfers
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    last      <= lst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // a key of n identical bytes, ending either on the last byte or on an
  // empty closing transfer
  task automatic send_fill_key(input int n, input logic [7:0] b, input logic end_on_byte);
    int i;
    for (i = 0; i < n; i++)
      send_item(b, 1'b1, end_on_byte && (i == n - 1));
    if (!end_on_byte)
      send_item(8'h00, 1'b0, 1'b1);
  endtask

  // out channel: ready bursts broken by random stalls
  initial begin : sink
    int run;
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int   items_sent;
    int   key_bytes;
    int   sel;
    int   i;
    logic end_on_byte;

    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    has_byte  = 1'b0;
    last      = 1'b0;
    steady    = 1'b0;
    items_sent = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty key straight after reset
    send_item(8'h00, 1'b0, 1'b1);
    // idle transfer, ignored by the core
    send_item(8'hff, 1'b0, 1'b0);
    // single byte carrying last
    send_item(8'hff, 1'b1, 1'b1);
    // exactly one block, last on the twelfth byte
    send_fill_key(12, 8'hff, 1'b1);
    // full tail of eleven zero bytes with an idle transfer inside,
    // closed by an empty transfer
    for (i = 0; i < 4; i++)
      send_item(8'h00, 1'b1, 1'b0);
    for (i = 0; i < 6; i++)
      send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // one block closed by an empty transfer, length only at the finish
    send_fill_key(12, 8'ha5, 1'b0);

    // random keys
    while (items_sent < RANDOM_ITEMS) begin
      // occasional stretch with no gaps on either side
      steady = ($urandom_range(0, 6) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0)
        key_bytes = $urandom_range(41, 100);
      else if (sel < 4)
        // around block boundaries
        key_bytes = 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
      else
        key_bytes = $urandom_range(0, 40);
      end_on_byte = (key_bytes > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < key_bytes; i++) begin
        // noise: idle transfers with random data
        if ($urandom_range(0, 19) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == key_bytes - 1));
        items_sent++;
      end
      if (!end_on_byte) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        items_sent++;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain every pending hash, then give the core time to go quiet
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("tb_lookup2_byte_hash_core passed");
    else
      $display("tb_lookup2_byte_hash_core failed");
    $finish;
  end

endmodule

>>> files.f
sv/lbh_pkg.sv
sv/lbh_front.sv
sv/lbh_queue.sv
sv/lbh_back.sv
sv/lookup2_byte_hash_core.sv
sv/lbh_checker.sv
bench/lookup2_byte_hash_checker.sv
bench/tb_lookup2_byte_hash_core.sv
